>>> src/met_pkg.sv
// Shared constants and handshake types for the escape-time block.
`timescale 1ns / 1ps
`default_nettype none

package met_pkg;

  localparam int FRAC_BITS = 28;

  localparam int IN_W      = 32;
  localparam int CNT_W     = 16;
  localparam int MAG_W     = 48;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_LIMIT  = 1'b1;

  localparam logic [CNT_W-1:0] ITER_LIMIT_RST = CNT_W'(256);
  localparam logic [MAG_W-1:0] ESC_LIMIT_RST  = MAG_W'(64'd4 << FRAC_BITS);

  // c, c - 0.25 and c + 1.0
  localparam int XP_W = IN_W + 1;
  localparam logic signed [XP_W-1:0] QUARTER = XP_W'(64'd1 << (FRAC_BITS - 2));
  localparam logic signed [XP_W-1:0] ONE     = XP_W'(64'd1 << FRAC_BITS);

  // shared multiplier: signed operands, two digits of magnitude each
  localparam int OP_W   = 52;
  localparam int DIG_W  = OP_W / 2;
  localparam int ACC_W  = 2 * OP_W;
  localparam int PROD_W = ACC_W + 1;

  // cardioid and bulb terms
  localparam int Y2_W = 35;
  localparam int Q_W  = 36;
  localparam int QX_W = 38;
  localparam logic [Q_W-1:0] BULB_LIM = Q_W'(64'd1 << (FRAC_BITS - 4));

  // iteration terms
  localparam int Z_W  = 50;
  localparam int SQ_W = ACC_W - FRAC_BITS;
  localparam int M_W  = SQ_W + 1;

  typedef struct packed {
    logic                   go;
    logic signed [OP_W-1:0] op_a;
    logic signed [OP_W-1:0] op_b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } mul_rsp_t;

endpackage

`default_nettype wire

>>> src/met_mul.sv
// Shared signed multiplier: one 26x26 digit product per cycle, accumulated.
`timescale 1ns / 1ps
`default_nettype none

module met_mul
  import met_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam logic [2:0] STEP_ABS      = 3'd0;
  localparam logic [2:0] STEP_PP_FIRST = 3'd1;
  localparam logic [2:0] STEP_PP_LAST  = 3'd4;
  localparam logic [2:0] STEP_OUT      = 3'd6;

  logic                     run_r;
  logic [2:0]               step_r;
  logic                     ppv_r;
  logic                     done_r;
  logic signed [OP_W-1:0]   opa_r;
  logic signed [OP_W-1:0]   opb_r;
  logic [OP_W-1:0]          maga_r;
  logic [OP_W-1:0]          magb_r;
  logic                     neg_r;
  logic [2*DIG_W-1:0]       pp_r;
  logic [1:0]               ppsel_r;
  logic [ACC_W-1:0]         acc_r;
  logic signed [PROD_W-1:0] prod_r;

  logic                     pp_step;
  logic [1:0]               pair;
  logic [DIG_W-1:0]         dig_a;
  logic [DIG_W-1:0]         dig_b;
  logic [ACC_W-1:0]         pp_ext;

  assign pp_step = run_r && (step_r >= STEP_PP_FIRST) && (step_r <= STEP_PP_LAST);
  assign pair    = 2'(step_r - STEP_PP_FIRST);
  assign dig_a   = pair[1] ? maga_r[OP_W-1:DIG_W] : maga_r[DIG_W-1:0];
  assign dig_b   = pair[0] ? magb_r[OP_W-1:DIG_W] : magb_r[DIG_W-1:0];

  always_comb begin
    unique case (ppsel_r)
      2'b00:        pp_ext = ACC_W'(pp_r);
      2'b01, 2'b10: pp_ext = ACC_W'(pp_r) << DIG_W;
      2'b11:        pp_ext = ACC_W'(pp_r) << (2 * DIG_W);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      step_r <= STEP_ABS;
      ppv_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      ppv_r  <= pp_step;
      if (req.go) begin
        run_r  <= 1'b1;
        step_r <= STEP_ABS;
      end else if (run_r) begin
        if (step_r == STEP_OUT) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      opa_r <= req.op_a;
      opb_r <= req.op_b;
    end
    if (run_r && step_r == STEP_ABS) begin
      maga_r <= opa_r[OP_W-1] ? ('0 - $unsigned(opa_r)) : $unsigned(opa_r);
      magb_r <= opb_r[OP_W-1] ? ('0 - $unsigned(opb_r)) : $unsigned(opb_r);
      neg_r  <= opa_r[OP_W-1] ^ opb_r[OP_W-1];
      acc_r  <= '0;
    end else if (ppv_r) begin
      acc_r <= acc_r + pp_ext;
    end
    if (pp_step) begin
      pp_r    <= dig_a * dig_b;
      ppsel_r <= pair;
    end
    if (run_r && step_r == STEP_OUT) begin
      prod_r <= neg_r ? (PROD_W'(0) - PROD_W'(acc_r)) : PROD_W'(acc_r);
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = prod_r;

  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.go |-> !run_r)
    else $error("multiplier restarted while busy");

  a_go_done: assert property (@(posedge clk) disable iff (!rst_n)
    req.go |-> ##8 rsp.done)
    else $error("product not ready eight cycles after go");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |=> !rsp.done)
    else $error("done held longer than one cycle");

endmodule

`default_nettype wire

>>> src/mandelbrot_escape_time_top.sv
// Escape-time test of one point: cardioid/bulb check, then z = z^2 + c.
// The result word follows setup alone when the cardioid or bulb test settles
// the point or the iteration limit is zero, otherwise it follows the iterations run.
// All work runs on the one shared multiplier (26x26 digit products): 4 products of setup,
// 3 products and a compare step per iteration. busy drops as out_valid shows.
// One item at a time; out_valid lasts one cycle and the receiver cannot stall.
// Sync active-low reset idles the sequencer, clears out_valid, limits to 256 and 4.0.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time_top
  import met_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [IN_W-1:0] in_point_re,
  input  logic signed [IN_W-1:0] in_point_im,
  output logic                   out_valid,
  output logic [CNT_W-1:0]       out_iteration_count,
  output logic                   out_inside_set,
  output logic [MAG_W-1:0]       out_final_magnitude_sq
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_Y2   = 9'b000000010,
    S_XX   = 9'b000000100,
    S_PP   = 9'b000001000,
    S_CARD = 9'b000010000,
    S_ZRI  = 9'b000100000,
    S_ZRR  = 9'b001000000,
    S_ZII  = 9'b010000000,
    S_CHK  = 9'b100000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         iter_limit_r;
  logic [MAG_W-1:0]         esc_limit_r;
  logic                     out_valid_r;
  logic [CNT_W-1:0]         out_count_r;
  logic                     out_inside_r;
  logic [MAG_W-1:0]         out_mag_r;

  logic signed [IN_W-1:0]   cr_r;
  logic signed [IN_W-1:0]   ci_r;
  logic [Y2_W-1:0]          y2_r;
  logic [Q_W-1:0]           q_r;
  logic                     bulb_r;
  logic signed [Z_W-1:0]    zr_r;
  logic signed [Z_W-1:0]    zi_r;
  logic [SQ_W-1:0]          a_r;
  logic [FRAC_BITS-1:0]     alo_r;
  logic [SQ_W-1:0]          b_r;
  logic [M_W-1:0]           m_r;
  logic [CNT_W-1:0]         iter_r;

  mul_req_t                 mul_req;
  mul_rsp_t                 mul_rsp;

  logic                     accept;
  logic                     fin_inside;
  logic                     fin_escape;
  logic signed [XP_W-1:0]   x_c;
  logic signed [XP_W-1:0]   p_c;
  logic [Y2_W-1:0]          sq_c;
  logic [Q_W-1:0]           sq_sum_c;
  logic signed [QX_W-1:0]   qx_c;
  logic signed [PROD_W-1:0] rhs_c;
  logic                     card_c;
  logic signed [Z_W-1:0]    zr_new_c;
  logic signed [Z_W-1:0]    zi_new_c;
  logic [SQ_W-1:0]          sqhi_c;
  logic [FRAC_BITS:0]       lo_sum_c;
  logic [M_W-1:0]           m_c;
  logic                     esc_c;
  logic [CNT_W-1:0]         iter_inc_c;

  met_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // setup terms
  assign x_c      = XP_W'(cr_r) - QUARTER;
  assign p_c      = XP_W'(cr_r) + ONE;
  assign sq_c     = mul_rsp.prod[FRAC_BITS +: Y2_W];
  assign sq_sum_c = Q_W'(sq_c) + Q_W'(y2_r);
  assign qx_c     = $signed({2'b00, q_r}) + QX_W'(x_c);
  assign rhs_c    = PROD_W'({y2_r, {(FRAC_BITS - 2){1'b0}}});
  assign card_c   = (mul_rsp.prod <= rhs_c);

  // iteration terms
  assign zr_new_c   = Z_W'(a_r) - Z_W'(b_r) + Z_W'(cr_r);
  assign zi_new_c   = Z_W'(mul_rsp.prod >>> (FRAC_BITS - 1)) + Z_W'(ci_r);
  assign sqhi_c     = mul_rsp.prod[FRAC_BITS +: SQ_W];
  assign lo_sum_c   = {1'b0, alo_r} + {1'b0, mul_rsp.prod[FRAC_BITS-1:0]};
  assign m_c        = M_W'(a_r) + M_W'(sqhi_c) + M_W'(lo_sum_c[FRAC_BITS]);
  assign esc_c      = (m_r > M_W'(esc_limit_r));
  assign iter_inc_c = iter_r + CNT_W'(1);

  always_comb begin
    state_nxt  = state_r;
    mul_req    = '0;
    fin_inside = 1'b0;
    fin_escape = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          mul_req.go   = 1'b1;
          mul_req.op_a = OP_W'(in_point_im);
          mul_req.op_b = OP_W'(in_point_im);
          state_nxt    = S_Y2;
        end
      end
      S_Y2: begin
        if (mul_rsp.done) begin
          mul_req.go   = 1'b1;
          mul_req.op_a = OP_W'(x_c);
          mul_req.op_b = OP_W'(x_c);
          state_nxt    = S_XX;
        end
      end
      S_XX: begin
        if (mul_rsp.done) begin
          mul_req.go   = 1'b1;
          mul_req.op_a = OP_W'(p_c);
          mul_req.op_b = OP_W'(p_c);
          state_nxt    = S_PP;
        end
      end
      S_PP: begin
        if (mul_rsp.done) begin
          mul_req.go   = 1'b1;
          mul_req.op_a = OP_W'(q_r);
          mul_req.op_b = OP_W'(qx_c);
          state_nxt    = S_CARD;
        end
      end
      S_CARD: begin
        if (mul_rsp.done) begin
          if (card_c || bulb_r || iter_limit_r == '0) begin
            fin_inside = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            mul_req.go   = 1'b1;
            mul_req.op_a = OP_W'(zr_r);
            mul_req.op_b = OP_W'(zi_r);
            state_nxt    = S_ZRI;
          end
        end
      end
      S_ZRI: begin
        if (mul_rsp.done) begin
          mul_req.go   = 1'b1;
          mul_req.op_a = OP_W'(zr_new_c);
          mul_req.op_b = OP_W'(zr_new_c);
          state_nxt    = S_ZRR;
        end
      end
      S_ZRR: begin
        if (mul_rsp.done) begin
          mul_req.go   = 1'b1;
          mul_req.op_a = OP_W'(zi_r);
          mul_req.op_b = OP_W'(zi_r);
          state_nxt    = S_ZII;
        end
      end
      S_ZII: begin
        if (mul_rsp.done) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (esc_c) begin
          fin_escape = 1'b1;
          state_nxt  = S_IDLE;
        end else if (iter_inc_c == iter_limit_r) begin
          fin_inside = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          mul_req.go   = 1'b1;
          mul_req.op_a = OP_W'(zr_r);
          mul_req.op_b = OP_W'(zi_r);
          state_nxt    = S_ZRI;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      iter_limit_r <= ITER_LIMIT_RST;
      esc_limit_r  <= ESC_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= fin_inside || fin_escape;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ITER_LIMIT: iter_limit_r <= cfg_data[CNT_W-1:0];
          CFG_ESC_LIMIT:  esc_limit_r  <= cfg_data[MAG_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cr_r   <= in_point_re;
      ci_r   <= in_point_im;
      zr_r   <= '0;
      zi_r   <= '0;
      a_r    <= '0;
      b_r    <= '0;
      iter_r <= '0;
    end
    if (mul_rsp.done) begin
      if (state_r == S_Y2) begin
        y2_r <= sq_c;
      end
      if (state_r == S_XX) begin
        q_r <= sq_sum_c;
      end
      if (state_r == S_PP) begin
        bulb_r <= (sq_sum_c <= BULB_LIM);
      end
      if (state_r == S_ZRI) begin
        zr_r <= zr_new_c;
        zi_r <= zi_new_c;
      end
      if (state_r == S_ZRR) begin
        a_r   <= sqhi_c;
        alo_r <= mul_rsp.prod[FRAC_BITS-1:0];
      end
      if (state_r == S_ZII) begin
        b_r <= sqhi_c;
        m_r <= m_c;
      end
    end
    if (state_r == S_CHK && !esc_c) begin
      iter_r <= iter_inc_c;
    end
    if (fin_inside) begin
      out_count_r  <= iter_limit_r;
      out_inside_r <= 1'b1;
      out_mag_r    <= '0;
    end else if (fin_escape) begin
      out_count_r  <= iter_r;
      out_inside_r <= 1'b0;
      // saturate the result word to 48 bits
      out_mag_r    <= (|m_r[M_W-1:MAG_W]) ? '1 : m_r[MAG_W-1:0];
    end
  end

  assign out_valid              = out_valid_r;
  assign out_iteration_count    = out_count_r;
  assign out_inside_set         = out_inside_r;
  assign out_final_magnitude_sq = out_mag_r;

  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word without a point in progress");

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("still busy while result word shown");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted point did not raise busy");

  a_escape_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_inside_set |-> out_iteration_count < iter_limit_r)
    else $error("escape count at or beyond iteration limit");

endmodule

`default_nettype wire
